// File: src/tsiq_pkg.sv
// package for the timestamp sorted insert queue
// operation codes and parameter defaults; no dependencies
package tsiq_pkg;

  localparam int DEPTH_DEF     = 256;
  localparam int TICK_BITS_DEF = 32;
  localparam int REF_BITS_DEF  = 16;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

endpackage

// File: src/tsiq_in_if.sv
// request channel of the timestamp sorted insert queue
// depends on tsiq_pkg for parameter defaults
interface tsiq_in_if #(
  parameter int TICK_BITS = tsiq_pkg::TICK_BITS_DEF,
  parameter int REF_BITS  = tsiq_pkg::REF_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [TICK_BITS-1:0] event_ticks;
  logic [REF_BITS-1:0]  event_ref;
  logic                 is_short_event;
  logic                 is_tempo_event;

  modport source (
    output valid, operation, event_ticks, event_ref, is_short_event, is_tempo_event,
    input  ready
  );
  modport sink (
    input  valid, operation, event_ticks, event_ref, is_short_event, is_tempo_event,
    output ready
  );
endinterface

// File: src/tsiq_out_if.sv
// result channel of the timestamp sorted insert queue
// depends on tsiq_pkg for parameter defaults
interface tsiq_out_if #(
  parameter int TICK_BITS = tsiq_pkg::TICK_BITS_DEF,
  parameter int REF_BITS  = tsiq_pkg::REF_BITS_DEF,
  parameter int DEPTH     = tsiq_pkg::DEPTH_DEF
);
  localparam int CW = $clog2(DEPTH + 1);

  logic                 valid;
  logic                 ready;
  logic [REF_BITS-1:0]  out_ref;
  logic [TICK_BITS-1:0] out_ticks;
  logic                 out_valid;
  logic                 stored;
  logic                 overflow;
  logic [CW-1:0]        entry_count;

  modport source (
    output valid, out_ref, out_ticks, out_valid, stored, overflow, entry_count,
    input  ready
  );
  modport sink (
    input  valid, out_ref, out_ticks, out_valid, stored, overflow, entry_count,
    output ready
  );
endinterface

// File: src/tsiq_ram.sv
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module tsiq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: src/timestamp_sorted_insert_queue.sv
// top level of the timestamp sorted insert queue
// depends on tsiq_pkg, tsiq_in_if, tsiq_out_if and tsiq_ram

// Holds up to DEPTH (tick, handle) entries in ascending tick order in one
// circular buffer memory; a new entry goes in front of the first entry whose
// tick is greater or equal. One request beat is taken at a time. A pop reads
// the head entry from idle and returns it from S_POPD (head read, then result);
// clear, dropped inserts, empty pops and an insert into an empty store finish
// straight from idle. An insert into a non-empty store walks the memory from
// the tail, reading and moving up one held entry per cycle while its tick is
// greater or equal to the new tick, then writes the new entry. A result beat
// that is not taken holds the block until it is.
module timestamp_sorted_insert_queue #(
  parameter int DEPTH     = tsiq_pkg::DEPTH_DEF,
  parameter int TICK_BITS = tsiq_pkg::TICK_BITS_DEF,
  parameter int REF_BITS  = tsiq_pkg::REF_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tsiq_in_if.sink    in_ch,
  tsiq_out_if.source out_ch
);
  import tsiq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = TICK_BITS + REF_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_POPD  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(DEPTH - 1) : a - 1'b1;
  endfunction

  logic [2:0]           state_r, state_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        left_r, left_nxt;
  logic [TICK_BITS-1:0] nt_r, nt_nxt;
  logic [REF_BITS-1:0]  nr_r, nr_nxt;

  // held result when the output register is still occupied
  logic [REF_BITS-1:0]  rref_r;
  logic [TICK_BITS-1:0] rticks_r;
  logic                 rval_r, rstored_r, rovf_r;
  logic [CW-1:0]        rcnt_r;

  // output register
  logic                 ovalid_r;
  logic [REF_BITS-1:0]  oref_r;
  logic [TICK_BITS-1:0] oticks_r;
  logic                 oval_r, ostored_r, oovf_r;
  logic [CW-1:0]        ocnt_r;

  // finishing result of the current cycle
  logic                 fin;
  logic [REF_BITS-1:0]  f_ref;
  logic [TICK_BITS-1:0] f_ticks;
  logic                 f_val, f_stored, f_ovf;

  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;
  logic [EW-1:0]        wdata, rdata;
  logic [TICK_BITS-1:0] rd_tick;
  logic [REF_BITS-1:0]  rd_ref;

  logic [AW:0]          tail_sum;
  logic [AW-1:0]        tail;
  logic                 out_free, acc, eligible;

  assign rd_tick  = rdata[REF_BITS +: TICK_BITS];
  assign rd_ref   = rdata[REF_BITS-1:0];
  assign out_free = !ovalid_r || out_ch.ready;
  assign acc      = (state_r == S_IDLE) && in_ch.valid;
  assign eligible = in_ch.is_short_event || in_ch.is_tempo_event;

  assign tail_sum = {1'b0, head_r} + (AW + 1)'(cnt_r);
  assign tail     = (tail_sum >= (AW + 1)'(DEPTH)) ?
                    AW'(tail_sum - (AW + 1)'(DEPTH)) : tail_sum[AW-1:0];

  tsiq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    left_nxt  = left_r;
    nt_nxt    = nt_r;
    nr_nxt    = nr_r;
    fin       = 1'b0;
    f_ref     = '0;
    f_ticks   = '0;
    f_val     = 1'b0;
    f_stored  = 1'b0;
    f_ovf     = 1'b0;
    we        = 1'b0;
    waddr     = tail;
    wdata     = {in_ch.event_ticks, in_ch.event_ref};
    re        = 1'b0;
    raddr     = head_r;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_ch.operation)
            OP_INSERT: begin
              if (!eligible) begin
                fin = 1'b1;
              end else if (cnt_r == CW'(DEPTH)) begin
                fin   = 1'b1;
                f_ovf = 1'b1;
              end else if (cnt_r == '0) begin
                we       = 1'b1;
                cnt_nxt  = cnt_r + 1'b1;
                fin      = 1'b1;
                f_stored = 1'b1;
              end else begin
                // walk down from the last held entry
                re        = 1'b1;
                raddr     = wrap_dec(tail);
                idx_nxt   = wrap_dec(tail);
                left_nxt  = cnt_r;
                cnt_nxt   = cnt_r + 1'b1;
                nt_nxt    = in_ch.event_ticks;
                nr_nxt    = in_ch.event_ref;
                state_nxt = S_SCAN;
              end
            end
            OP_POP: begin
              if (cnt_r == '0) begin
                fin = 1'b1;
              end else begin
                re        = 1'b1;
                raddr     = head_r;
                head_nxt  = wrap_inc(head_r);
                cnt_nxt   = cnt_r - 1'b1;
                state_nxt = S_POPD;
              end
            end
            OP_CLEAR: begin
              cnt_nxt = '0;
              fin     = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        waddr = wrap_inc(idx_r);
        we    = 1'b1;
        if (rd_tick >= nt_r) begin
          // move this entry up one slot
          wdata = rdata;
          if (left_r == CW'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            re       = 1'b1;
            raddr    = wrap_dec(idx_r);
            idx_nxt  = wrap_dec(idx_r);
            left_nxt = left_r - 1'b1;
          end
        end else begin
          wdata    = {nt_r, nr_r};
          fin      = 1'b1;
          f_stored = 1'b1;
        end
      end
      S_PLACE: begin
        we       = 1'b1;
        waddr    = idx_r;
        wdata    = {nt_r, nr_r};
        fin      = 1'b1;
        f_stored = 1'b1;
      end
      S_POPD: begin
        fin     = 1'b1;
        f_ref   = rd_ref;
        f_ticks = rd_tick;
        f_val   = 1'b1;
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = out_free ? S_IDLE : S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_EMIT && out_free) begin
        ovalid_r <= 1'b1;
      end else if (fin && out_free) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    left_r <= left_nxt;
    nt_r   <= nt_nxt;
    nr_r   <= nr_nxt;
    if (fin && !out_free) begin
      rref_r    <= f_ref;
      rticks_r  <= f_ticks;
      rval_r    <= f_val;
      rstored_r <= f_stored;
      rovf_r    <= f_ovf;
      rcnt_r    <= cnt_nxt;
    end
    if (state_r == S_EMIT && out_free) begin
      oref_r    <= rref_r;
      oticks_r  <= rticks_r;
      oval_r    <= rval_r;
      ostored_r <= rstored_r;
      oovf_r    <= rovf_r;
      ocnt_r    <= rcnt_r;
    end else if (fin && out_free) begin
      oref_r    <= f_ref;
      oticks_r  <= f_ticks;
      oval_r    <= f_val;
      ostored_r <= f_stored;
      oovf_r    <= f_ovf;
      ocnt_r    <= cnt_nxt;
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = ovalid_r;
  assign out_ch.out_ref     = oref_r;
  assign out_ch.out_ticks   = oticks_r;
  assign out_ch.out_valid   = oval_r;
  assign out_ch.stored      = ostored_r;
  assign out_ch.overflow    = oovf_r;
  assign out_ch.entry_count = ocnt_r;

endmodule
